@@ design/sum16_packet_deframer_top_assert.svh @@
// Assertion macros shared by the deframer checker.
`ifndef SUM16_PACKET_DEFRAMER_TOP_ASSERT_SVH
`define SUM16_PACKET_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SUM16_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, disabled during reset.
`define SUM16_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

@@ design/sum16_pd_pkg.sv @@
// Package: types, codes and constants of the packet deframer.
package sum16_pd_pkg;

  localparam int unsigned PidW     = 8;
  localparam int unsigned LenW     = 16;
  localparam int unsigned TicksW   = 18;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 18;

  localparam logic [7:0] HdrFirst  = 8'hEF;
  localparam logic [7:0] HdrSecond = 8'h01;
  localparam logic [7:0] PidAck    = 8'h07;
  localparam logic [LenW-1:0]   MaxLenReset  = 16'd64;
  localparam logic [TicksW-1:0] TimeoutReset = 18'd200000;
  localparam logic [LenW:0]     HeadBytes    = 17'd9;
  localparam logic [LenW:0]     SumBytes     = 17'd2;

  localparam logic [LenW-1:0] PosPid    = 16'd6;
  localparam logic [LenW-1:0] PosLenHi  = 16'd7;
  localparam logic [LenW-1:0] PosLenLo  = 16'd8;
  localparam logic [LenW-1:0] PosHdr0   = 16'd0;
  localparam logic [LenW-1:0] PosHdr1   = 16'd1;

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_ARM  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;
  localparam logic [1:0] ST_CSUM    = 2'd3;

  localparam logic KIND_CONTENT = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_PID     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LEN = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic            kind;
    logic [7:0]      content_byte;
    logic [1:0]      status;
    logic [LenW-1:0] frame_length;
    logic            last;
  } result_t;

  typedef struct packed {
    logic [PidW-1:0]   pid;
    logic [LenW-1:0]   max_len;
    logic [TicksW-1:0] timeout;
  } cfg_t;

endpackage

@@ design/sum16_pd_if.sv @@
// Interfaces: input word, result word and configuration write channels.
interface sum16_pd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface sum16_pd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [7:0]                    content_byte;
  logic [1:0]                    status;
  logic [sum16_pd_pkg::LenW-1:0] frame_length;
  logic                          last;
  modport source (output valid, output kind, output content_byte, output status,
                  output frame_length, output last, input ready);
  modport sink (input valid, input kind, input content_byte, input status,
                input frame_length, input last, output ready);
endinterface

interface sum16_pd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [sum16_pd_pkg::CfgIdxW-1:0]  index;
  logic [sum16_pd_pkg::CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/sum16_packet_deframer_top.sv @@
// Top level of the sum16 packet deframer.
// The deframer takes one word per cycle on in_i (byte, tick or arm) and
// returns at most one result word per input word on out_o: content bytes as
// they arrive and at most one final status (ok with total length, timeout, bad
// packet, checksum error) per packet. Every word passes an input register and
// a result register, in that order, before its result word is offered on
// out_o; throughput stays at one word per cycle as long as out_o is drained,
// and in_i.ready follows out_o.ready in the same cycle when both registers
// are full. Configuration writes on cfg_i are always ready and take effect
// on the next cycle; write them only while no packet is in flight.
module sum16_packet_deframer_top (
  input logic           clk_i,
  input logic           rst_ni,
  sum16_pd_in_if.sink   in_i,
  sum16_pd_out_if.source out_o,
  sum16_pd_cfg_if.sink  cfg_i
);

  sum16_pd_pkg::cfg_t    cfg;
  sum16_pd_pkg::item_t   in_item;
  sum16_pd_pkg::item_t   cur_item;
  sum16_pd_pkg::result_t core_res;
  sum16_pd_pkg::result_t out_res;
  logic                  cur_valid;
  logic                  out_free;
  logic                  advance;
  logic                  core_res_valid;

  assign cfg_i.ready = 1'b1;

  sum16_pd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_i.valid),
    .index_i (cfg_i.index),
    .data_i  (cfg_i.data),
    .cfg_o   (cfg)
  );

  assign in_item.opcode    = in_i.opcode;
  assign in_item.data_byte = in_i.data_byte;

  sum16_pd_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_i.valid),
    .item_i    (in_item),
    .ready_o   (in_i.ready),
    .advance_i (advance),
    .valid_o   (cur_valid),
    .item_o    (cur_item)
  );

  assign advance = cur_valid && out_free;

  sum16_pd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (cur_item),
    .cfg_i       (cfg),
    .res_valid_o (core_res_valid),
    .res_o       (core_res)
  );

  sum16_pd_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (core_res_valid),
    .res_i   (core_res),
    .free_o  (out_free),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (out_res)
  );

  assign out_o.kind         = out_res.kind;
  assign out_o.content_byte = out_res.content_byte;
  assign out_o.status       = out_res.status;
  assign out_o.frame_length = out_res.frame_length;
  assign out_o.last         = out_res.last;

endmodule

@@ design/sum16_pd_cfg.sv @@
// Configuration registers of the packet deframer.
module sum16_pd_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_i,
  input  logic [sum16_pd_pkg::CfgIdxW-1:0]  index_i,
  input  logic [sum16_pd_pkg::CfgDataW-1:0] data_i,
  output sum16_pd_pkg::cfg_t                cfg_o
);

  sum16_pd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      case (index_i)
        sum16_pd_pkg::CFG_PID:     cfg_d.pid     = data_i[sum16_pd_pkg::PidW-1:0];
        sum16_pd_pkg::CFG_MAX_LEN: cfg_d.max_len = data_i[sum16_pd_pkg::LenW-1:0];
        sum16_pd_pkg::CFG_TIMEOUT: cfg_d.timeout = data_i[sum16_pd_pkg::TicksW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pid     <= sum16_pd_pkg::PidAck;
      cfg_q.max_len <= sum16_pd_pkg::MaxLenReset;
      cfg_q.timeout <= sum16_pd_pkg::TimeoutReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/sum16_pd_in_stage.sv @@
// Input register: holds one accepted word until the core advances.
module sum16_pd_in_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  sum16_pd_pkg::item_t   item_i,
  output logic                  ready_o,
  input  logic                  advance_i,
  output logic                  valid_o,
  output sum16_pd_pkg::item_t   item_o
);

  logic                valid_q, valid_d;
  sum16_pd_pkg::item_t item_q;
  logic                load;

  assign ready_o = !valid_q || advance_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (advance_i) valid_d = 1'b0;
    if (load) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) item_q <= item_i;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ design/sum16_pd_core.sv @@
// Deframer core: packet state and per-word next-state and result logic.
module sum16_pd_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  sum16_pd_pkg::item_t   item_i,
  input  sum16_pd_pkg::cfg_t    cfg_i,
  output logic                  res_valid_o,
  output sum16_pd_pkg::result_t res_o
);

  localparam int unsigned LenW   = sum16_pd_pkg::LenW;
  localparam int unsigned TicksW = sum16_pd_pkg::TicksW;

  typedef enum logic [1:0] {PH_IDLE, PH_HEAD, PH_BODY} phase_e;

  phase_e            phase_q, phase_d;
  logic [LenW-1:0]   pos_q, pos_d;
  logic              hdr_ok_q, hdr_ok_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [LenW-1:0]   sum_q, sum_d;
  logic [7:0]        csum_hi_q, csum_hi_d;
  logic [TicksW-1:0] ticks_q, ticks_d;

  logic [7:0]        b;
  logic [TicksW-1:0] tick_inc;
  logic [LenW-1:0]   len_full;
  logic [LenW:0]     head_total;
  logic [LenW:0]     body_total;
  logic [LenW:0]     body_lim;
  logic [LenW:0]     pos_ext;
  logic [LenW-1:0]   sum_inc;

  assign b          = item_i.data_byte;
  assign tick_inc   = ticks_q + {{(TicksW-1){1'b0}}, 1'b1};
  assign len_full   = {len_q[LenW-1:8], b};
  assign head_total = sum16_pd_pkg::HeadBytes + {1'b0, len_full};
  assign body_total = sum16_pd_pkg::HeadBytes + {1'b0, len_q};
  assign body_lim   = body_total - sum16_pd_pkg::SumBytes;
  assign pos_ext    = {1'b0, pos_q};
  assign sum_inc    = sum_q + {{(LenW-8){1'b0}}, b};

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    hdr_ok_d    = hdr_ok_q;
    len_d       = len_q;
    sum_d       = sum_q;
    csum_hi_d   = csum_hi_q;
    ticks_d     = ticks_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i) begin
      case (item_i.opcode)
        sum16_pd_pkg::OP_ARM: begin
          phase_d   = PH_HEAD;
          pos_d     = '0;
          hdr_ok_d  = 1'b1;
          len_d     = '0;
          sum_d     = '0;
          csum_hi_d = '0;
          ticks_d   = '0;
        end
        sum16_pd_pkg::OP_TICK: begin
          if (phase_q != PH_IDLE) begin
            ticks_d = tick_inc;
            if (tick_inc >= cfg_i.timeout || tick_inc == '0) begin
              phase_d     = PH_IDLE;
              res_valid_o = 1'b1;
              res_o.kind  = sum16_pd_pkg::KIND_STATUS;
              res_o.status = sum16_pd_pkg::ST_TIMEOUT;
              res_o.last  = 1'b1;
            end
          end
        end
        sum16_pd_pkg::OP_BYTE: begin
          if (phase_q != PH_IDLE) begin
            ticks_d = '0;
            pos_d   = pos_q + {{(LenW-1){1'b0}}, 1'b1};
          end
          case (phase_q)
            PH_HEAD: begin
              if ((pos_q == sum16_pd_pkg::PosHdr0 && b != sum16_pd_pkg::HdrFirst) ||
                  (pos_q == sum16_pd_pkg::PosHdr1 && b != sum16_pd_pkg::HdrSecond) ||
                  (pos_q == sum16_pd_pkg::PosPid && b != cfg_i.pid)) begin
                hdr_ok_d = 1'b0;
              end
              if (pos_q >= sum16_pd_pkg::PosPid) sum_d = sum_inc;
              if (pos_q == sum16_pd_pkg::PosLenHi) len_d = {b, 8'h00};
              if (pos_q == sum16_pd_pkg::PosLenLo) begin
                len_d = len_full;
                if (!hdr_ok_q || {1'b0, len_full} < sum16_pd_pkg::SumBytes ||
                    head_total > {1'b0, cfg_i.max_len}) begin
                  phase_d      = PH_IDLE;
                  res_valid_o  = 1'b1;
                  res_o.kind   = sum16_pd_pkg::KIND_STATUS;
                  res_o.status = sum16_pd_pkg::ST_BAD;
                  res_o.last   = 1'b1;
                end else begin
                  phase_d = PH_BODY;
                end
              end
            end
            PH_BODY: begin
              if (pos_ext < body_lim) begin
                sum_d              = sum_inc;
                res_valid_o        = 1'b1;
                res_o.kind         = sum16_pd_pkg::KIND_CONTENT;
                res_o.content_byte = b;
              end else if (pos_ext == body_lim) begin
                csum_hi_d = b;
              end else begin
                phase_d     = PH_IDLE;
                res_valid_o = 1'b1;
                res_o.kind  = sum16_pd_pkg::KIND_STATUS;
                res_o.last  = 1'b1;
                if ({csum_hi_q, b} == sum_q) begin
                  res_o.status       = sum16_pd_pkg::ST_OK;
                  res_o.frame_length = body_total[LenW-1:0];
                end else begin
                  res_o.status = sum16_pd_pkg::ST_CSUM;
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      pos_q     <= '0;
      hdr_ok_q  <= 1'b1;
      len_q     <= '0;
      sum_q     <= '0;
      csum_hi_q <= '0;
      ticks_q   <= '0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      hdr_ok_q  <= hdr_ok_d;
      len_q     <= len_d;
      sum_q     <= sum_d;
      csum_hi_q <= csum_hi_d;
      ticks_q   <= ticks_d;
    end
  end

endmodule

@@ design/sum16_pd_out_stage.sv @@
// Result register: holds one result word until the sink takes it.
module sum16_pd_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  sum16_pd_pkg::result_t res_i,
  output logic                  free_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output sum16_pd_pkg::result_t res_o
);

  logic                  valid_q, valid_d;
  sum16_pd_pkg::result_t res_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (valid_q && ready_i) valid_d = 1'b0;
    if (load_i) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ design/sum16_pd_checker.sv @@
// Port-level checker for the packet deframer, bound to the top level.
`include "sum16_packet_deframer_top_assert.svh"

module sum16_pd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          kind_i,
  input logic [7:0]                    content_byte_i,
  input logic [1:0]                    status_i,
  input logic [sum16_pd_pkg::LenW-1:0] frame_length_i,
  input logic                          last_i
);

  `SUM16_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(kind_i) && $stable(content_byte_i) && $stable(status_i) && $stable(frame_length_i) && $stable(last_i))

  `SUM16_ASSERT_NOW(a_content_clean, clk_i, rst_ni, out_valid_i && kind_i == sum16_pd_pkg::KIND_CONTENT,
    !last_i && status_i == sum16_pd_pkg::ST_OK && frame_length_i == '0)

  `SUM16_ASSERT_NOW(a_status_last, clk_i, rst_ni, out_valid_i && kind_i == sum16_pd_pkg::KIND_STATUS,
    last_i && content_byte_i == '0 && (status_i == sum16_pd_pkg::ST_OK || frame_length_i == '0))

  `SUM16_ASSERT_NOW(a_ok_length, clk_i, rst_ni, out_valid_i && kind_i == sum16_pd_pkg::KIND_STATUS && status_i == sum16_pd_pkg::ST_OK,
    frame_length_i >= 16'd11)

endmodule

bind sum16_packet_deframer_top sum16_pd_checker u_sum16_pd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .kind_i         (out_o.kind),
  .content_byte_i (out_o.content_byte),
  .status_i       (out_o.status),
  .frame_length_i (out_o.frame_length),
  .last_i         (out_o.last)
);

@@ verif/tb_top.sv @@
// Testbench of the sum16 packet deframer: directed table, then random packets checked by a model.
`timescale 1ns / 100ps

module tb_top;
  import sum16_pd_pkg::*;

  localparam logic [1:0] OP_RESERVED  = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  localparam result_t RES_TIMEOUT = {KIND_STATUS, 8'h00, ST_TIMEOUT, 16'd0, 1'b1};
  localparam result_t RES_OK_MIN  = {KIND_STATUS, 8'h00, ST_OK, 16'd11, 1'b1};

  typedef enum logic [1:0] {RX_IDLE, RX_HEAD, RX_BODY} rx_phase_e;
  typedef enum int {
    FLAW_NONE, FLAW_HDR0, FLAW_HDR1, FLAW_PID, FLAW_SHORT, FLAW_LONG, FLAW_CSUM,
    FLAW_REARM, FLAW_STALL
  } flaw_e;
  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [1:0]  sel;
    logic [17:0] value;
    bit          typed;
    result_t     res;
  } stim_row_t;

  logic clk;
  logic rst_n;

  sum16_pd_in_if  in_if ();
  sum16_pd_out_if out_if ();
  sum16_pd_cfg_if cfg_if ();

  sum16_packet_deframer_top u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  logic [PidW-1:0]   cfg_pid     = PidAck;
  logic [LenW-1:0]   cfg_max_len = MaxLenReset;
  logic [TicksW-1:0] cfg_timeout = TimeoutReset;

  rx_phase_e         rx_phase  = RX_IDLE;
  logic [LenW-1:0]   rx_pos    = '0;
  logic              hdr_good  = 1'b1;
  logic [LenW-1:0]   len_field = '0;
  logic [15:0]       sum_acc   = '0;
  logic [7:0]        sum_hi    = '0;
  logic [TicksW-1:0] tick_cnt  = '0;

  result_t     expected_results[$];
  stim_row_t   directed_rows[$];
  int unsigned error_count = 0;
  int unsigned live_items  = 0;
  int unsigned cfg_changes = 0;
  int unsigned cycle_count = 0;
  int unsigned src_mode    = 0;
  int unsigned sink_mode   = 0;
  int unsigned n_content = 0, n_ok = 0, n_timeout = 0, n_bad = 0, n_csum = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned draw_gap(inout int unsigned mode);
    if ($urandom_range(0, 31) == 0) mode = $urandom_range(0, 2);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 18);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
    endcase
  endfunction

  function automatic result_t end_word(logic [1:0] st, logic [LenW-1:0] len);
    rx_phase = RX_IDLE;
    return {KIND_STATUS, 8'h00, st, (st == ST_OK) ? len : 16'd0, 1'b1};
  endfunction

  function automatic bit deframe_step(input logic [1:0] op, input logic [7:0] b,
                                      output result_t r);
    logic [LenW-1:0] pos;
    logic [LenW:0]   total;
    r = '0;
    if (op == OP_ARM) begin
      rx_phase  = RX_HEAD;
      rx_pos    = '0;
      hdr_good  = 1'b1;
      len_field = '0;
      sum_acc   = '0;
      sum_hi    = '0;
      tick_cnt  = '0;
      return 1'b0;
    end
    if (rx_phase == RX_IDLE || op == OP_RESERVED) return 1'b0;
    if (op == OP_TICK) begin
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= cfg_timeout || tick_cnt == '0) begin
        r = end_word(ST_TIMEOUT, '0);
        return 1'b1;
      end
      return 1'b0;
    end
    tick_cnt = '0;
    pos      = rx_pos;
    rx_pos   = rx_pos + 1'b1;
    if (rx_phase == RX_HEAD) begin
      if ((pos == PosHdr0 && b != HdrFirst) || (pos == PosHdr1 && b != HdrSecond) ||
          (pos == PosPid && b != cfg_pid))
        hdr_good = 1'b0;
      if (pos >= PosPid) sum_acc = sum_acc + 16'(b);
      if (pos == PosLenHi) len_field = {b, 8'h00};
      if (pos == PosLenLo) begin
        len_field = {len_field[15:8], b};
        total = HeadBytes + len_field;
        if (!hdr_good || len_field < SumBytes || total > cfg_max_len) begin
          r = end_word(ST_BAD, '0);
          return 1'b1;
        end
        rx_phase = RX_BODY;
      end
      return 1'b0;
    end
    total = HeadBytes + len_field;
    if (pos < total - SumBytes) begin
      sum_acc = sum_acc + 16'(b);
      r = {KIND_CONTENT, b, ST_OK, 16'd0, 1'b0};
      return 1'b1;
    end
    if (pos == total - SumBytes) begin
      sum_hi = b;
      return 1'b0;
    end
    r = ({sum_hi, b} == sum_acc) ? end_word(ST_OK, total[LenW-1:0]) : end_word(ST_CSUM, '0);
    return 1'b1;
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [7:0] b,
                           input bit typed = 1'b0, input result_t typed_res = '0);
    int unsigned gap;
    result_t     pred;
    bit          has_res;
    gap = draw_gap(src_mode);
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid     = 1'b1;
    in_if.opcode    = op;
    in_if.data_byte = b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (rx_phase != RX_IDLE || op == OP_ARM) live_items++;
    has_res = deframe_step(op, b, pred);
    if (typed) expected_results.push_back(typed_res);
    else if (has_res) expected_results.push_back(pred);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_PID:     cfg_pid = val[PidW-1:0];
      CFG_MAX_LEN: cfg_max_len = val[LenW-1:0];
      CFG_TIMEOUT: cfg_timeout = val[TicksW-1:0];
      default: ;
    endcase
    cfg_changes++;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic run_episode();
    logic [7:0]  frame[$];
    logic [15:0] plen;
    logic [15:0] csum;
    flaw_e       flaw;
    int unsigned cap, n, cut, pick, tick_room;
    if ($urandom_range(0, 9) < 2) begin
      repeat ($urandom_range(1, 6)) send_item(2'($urandom_range(0, 3)), 8'($urandom));
      return;
    end
    flaw = ($urandom_range(0, 9) < 7) ? FLAW_NONE : flaw_e'($urandom_range(1, 8));
    cap  = (int'(cfg_max_len) >= 11) ? int'(cfg_max_len) - 11 : 0;
    pick = $urandom_range(0, 7);
    if (flaw == FLAW_LONG) n = $urandom_range(0, 3);
    else if (pick == 0 && cap <= 300) n = cap;
    else if (pick == 1 && cap >= 250) n = $urandom_range(250, (cap < 300) ? cap : 300);
    else n = $urandom_range(0, (cap < 12) ? cap : 12);
    plen = 16'(n + 2);
    if (flaw == FLAW_SHORT) plen = 16'($urandom_range(0, 1));
    if (flaw == FLAW_LONG) plen = 16'($urandom_range(int'(cfg_max_len) - 8, 65535));

    frame.push_back((flaw == FLAW_HDR0) ? HdrFirst ^ 8'($urandom_range(1, 255)) : HdrFirst);
    frame.push_back((flaw == FLAW_HDR1) ? HdrSecond ^ 8'($urandom_range(1, 255)) : HdrSecond);
    repeat (4) frame.push_back(8'($urandom));
    frame.push_back((flaw == FLAW_PID) ? cfg_pid ^ 8'($urandom_range(1, 255)) : cfg_pid);
    frame.push_back(plen[15:8]);
    frame.push_back(plen[7:0]);
    repeat (n) frame.push_back(8'($urandom));
    csum = '0;
    for (int i = 6; i < frame.size(); i++) csum = csum + 16'(frame[i]);
    if (flaw == FLAW_CSUM) csum = csum ^ 16'($urandom_range(1, 65535));
    frame.push_back(csum[15:8]);
    frame.push_back(csum[7:0]);

    cut = frame.size();
    if (flaw == FLAW_LONG) cut = 9 + $urandom_range(0, 2);
    if (flaw == FLAW_REARM || flaw == FLAW_STALL) cut = $urandom_range(0, frame.size() - 1);
    tick_room = (cfg_timeout > 4) ? 3 : int'(cfg_timeout) - 1;

    send_item(OP_ARM, 8'($urandom));
    for (int i = 0; i < cut; i++) begin
      if (cfg_timeout > 1 && $urandom_range(0, 15) == 0)
        repeat ($urandom_range(1, tick_room)) send_item(OP_TICK, 8'($urandom));
      if ($urandom_range(0, 39) == 0) send_item(OP_RESERVED, 8'($urandom));
      send_item(OP_BYTE, frame[i]);
    end
    if (flaw == FLAW_STALL && cfg_timeout <= 64)
      repeat ((cfg_timeout == 0) ? 1 : int'(cfg_timeout)) send_item(OP_TICK, 8'($urandom));
  endtask

  // result word monitor and scoreboard
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = {out_if.kind, out_if.content_byte, out_if.status, out_if.frame_length, out_if.last};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word kind=%0d byte=%02h status=%0d len=%0d last=%0d",
                 $time, got.kind, got.content_byte, got.status, got.frame_length, got.last);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind || got.content_byte !== want.content_byte ||
            got.status !== want.status || got.frame_length !== want.frame_length ||
            got.last !== want.last) begin
          $display("%0t: result word mismatch: expected kind=%0d byte=%02h status=%0d len=%0d last=%0d",
                   $time, want.kind, want.content_byte, want.status, want.frame_length, want.last);
          $display("%0t:                       actual   kind=%0d byte=%02h status=%0d len=%0d last=%0d",
                   $time, got.kind, got.content_byte, got.status, got.frame_length, got.last);
          error_count++;
        end
        if (want.kind == KIND_CONTENT) n_content++;
        else begin
          case (want.status)
            ST_OK:      n_ok++;
            ST_TIMEOUT: n_timeout++;
            ST_BAD:     n_bad++;
            default:    n_csum++;
          endcase
        end
      end
    end
  end

  // result sink with random back-pressure
  initial begin
    int unsigned hold;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      hold = draw_gap(sink_mode);
      if (hold > 0) begin
        @(negedge clk);
        out_if.ready = 1'b0;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_if.ready = 1'b1;
      @(posedge clk);
      while (!(out_if.valid && out_if.ready)) @(posedge clk);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: watchdog expired after %0d cycles, %0d words still expected",
             cycle_count, expected_results.size());
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    int unsigned phase_no;
    int unsigned phase_start;
    int unsigned target;
    logic [17:0] s_pid, s_max, s_tmo;

    in_if.valid     = 1'b0;
    in_if.opcode    = OP_BYTE;
    in_if.data_byte = 8'h00;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_PID;
    cfg_if.data     = '0;
    rst_n           = 1'b0;

    directed_rows.push_back('{ROW_CFG,  CFG_TIMEOUT, 18'd2,   1'b0, '0});
    directed_rows.push_back('{ROW_ITEM, OP_BYTE,     18'hFF,  1'b0, '0});
    directed_rows.push_back('{ROW_ITEM, OP_TICK,     18'h00,  1'b0, '0});
    directed_rows.push_back('{ROW_ITEM, OP_RESERVED, 18'h00,  1'b0, '0});
    directed_rows.push_back('{ROW_ITEM, OP_ARM,      18'h00,  1'b0, '0});
    directed_rows.push_back('{ROW_ITEM, OP_TICK,     18'h00,  1'b0, '0});
    directed_rows.push_back('{ROW_ITEM, OP_TICK,     18'hFF,  1'b1, RES_TIMEOUT});
    directed_rows.push_back('{ROW_ITEM, OP_ARM,      18'hFF,  1'b0, '0});
    directed_rows.push_back('{ROW_ITEM, OP_BYTE,     18'hEF,  1'b0, '0});
    directed_rows.push_back('{ROW_ITEM, OP_BYTE,     18'h01,  1'b0, '0});
    directed_rows.push_back('{ROW_ITEM, OP_ARM,      18'h00,  1'b0, '0});
    directed_rows.push_back('{ROW_ITEM, OP_BYTE,     18'hEF,  1'b0, '0});
    directed_rows.push_back('{ROW_ITEM, OP_BYTE,     18'h01,  1'b0, '0});
    directed_rows.push_back('{ROW_ITEM, OP_BYTE,     18'h00,  1'b0, '0});
    directed_rows.push_back('{ROW_ITEM, OP_BYTE,     18'hFF,  1'b0, '0});
    directed_rows.push_back('{ROW_ITEM, OP_RESERVED, 18'hAA,  1'b0, '0});
    directed_rows.push_back('{ROW_ITEM, OP_BYTE,     18'h00,  1'b0, '0});
    directed_rows.push_back('{ROW_ITEM, OP_BYTE,     18'hFF,  1'b0, '0});
    directed_rows.push_back('{ROW_ITEM, OP_BYTE,     18'h07,  1'b0, '0});
    directed_rows.push_back('{ROW_ITEM, OP_BYTE,     18'h00,  1'b0, '0});
    directed_rows.push_back('{ROW_ITEM, OP_BYTE,     18'h02,  1'b0, '0});
    directed_rows.push_back('{ROW_ITEM, OP_BYTE,     18'h00,  1'b0, '0});
    directed_rows.push_back('{ROW_ITEM, OP_BYTE,     18'h09,  1'b1, RES_OK_MIN});
    directed_rows.push_back('{ROW_CFG,  CFG_TIMEOUT, 18'd0,   1'b0, '0});
    directed_rows.push_back('{ROW_ITEM, OP_ARM,      18'h55,  1'b0, '0});
    directed_rows.push_back('{ROW_ITEM, OP_TICK,     18'hAA,  1'b1, RES_TIMEOUT});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_drained();
        cfg_write(directed_rows[i].sel, directed_rows[i].value);
      end else begin
        send_item(directed_rows[i].sel, directed_rows[i].value[7:0], directed_rows[i].typed,
                  directed_rows[i].res);
      end
    end

    target   = live_items + RANDOM_ITEMS;
    phase_no = 0;
    while (live_items < target) begin
      wait_drained();
      case (phase_no)
        0: begin s_pid = 18'd7;   s_max = 18'd64;    s_tmo = 18'd20;     end
        1: begin s_pid = 18'd0;   s_max = 18'd11;    s_tmo = 18'd1;      end
        2: begin s_pid = 18'd255; s_max = 18'd65535; s_tmo = 18'd262143; end
        3: begin s_pid = 18'($urandom_range(0, 255)); s_max = 18'd10; s_tmo = 18'd0; end
        default: begin
          s_pid = 18'($urandom_range(0, 255));
          case ($urandom_range(0, 2))
            0: s_max = 18'(11 + $urandom_range(0, 10));
            1: s_max = 18'($urandom_range(11, 120));
            default: s_max = 18'($urandom_range(11, 65535));
          endcase
          s_tmo = ($urandom_range(0, 3) == 0) ? 18'($urandom_range(41, 262143))
                                              : 18'($urandom_range(1, 40));
        end
      endcase
      cfg_write(CFG_PID, s_pid);
      cfg_write(CFG_MAX_LEN, s_max);
      cfg_write(CFG_TIMEOUT, s_tmo);
      phase_start = live_items;
      while (live_items - phase_start < PHASE_ITEMS && live_items < target) run_episode();
      phase_no++;
    end

    wait_drained();
    $display("tb_top: %0d live input words over %0d register settings, %0d content words",
             live_items, cfg_changes, n_content);
    $display("tb_top: status words ok %0d, timeout %0d, bad packet %0d, checksum error %0d",
             n_ok, n_timeout, n_bad, n_csum);
    if (error_count == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
